// ===== sv/adaptive_binary_arith_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// adaptive_binary_arith_encoder_assert
// Assertion macros used by the encoder datapath.
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BINARY_ARITH_ENCODER_ASSERT_SVH
`define ADAPTIVE_BINARY_ARITH_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define ABAE_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("abae check failed");

// Next-cycle implication.
`define ABAE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("abae check failed");

`endif

// ===== sv/abae_pkg.sv =====
// ----------------------------------------------------------------------------
// abae_pkg
// Types, constants and the adaptation table of the binary arithmetic encoder.
// ----------------------------------------------------------------------------
package abae_pkg;

    localparam int NUM_CONTEXTS    = 128;
    localparam int CTX_W           = $clog2(NUM_CONTEXTS);
    localparam int MAX_OUTSTANDING = 16;

    localparam logic        OPER_ENCODE = 1'b0;
    localparam logic        OPER_FLUSH  = 1'b1;
    localparam logic [15:0] PROB_INIT   = 16'h8000;
    localparam logic [15:0] RANGE_INIT  = 16'hffff;
    localparam logic [15:0] RENORM_MAX  = 16'h4000;

    localparam logic [15:0] ADAPT_ROM [256] = '{
        16'd0,    16'd2,    16'd5,    16'd8,    16'd11,   16'd15,   16'd20,   16'd24,
        16'd29,   16'd35,   16'd41,   16'd47,   16'd53,   16'd60,   16'd67,   16'd74,
        16'd82,   16'd89,   16'd97,   16'd106,  16'd114,  16'd123,  16'd132,  16'd141,
        16'd150,  16'd160,  16'd170,  16'd180,  16'd190,  16'd201,  16'd211,  16'd222,
        16'd233,  16'd244,  16'd256,  16'd267,  16'd279,  16'd291,  16'd303,  16'd315,
        16'd327,  16'd340,  16'd353,  16'd366,  16'd379,  16'd392,  16'd405,  16'd419,
        16'd433,  16'd447,  16'd461,  16'd475,  16'd489,  16'd504,  16'd518,  16'd533,
        16'd548,  16'd563,  16'd578,  16'd593,  16'd609,  16'd624,  16'd640,  16'd656,
        16'd672,  16'd688,  16'd705,  16'd721,  16'd738,  16'd754,  16'd771,  16'd788,
        16'd805,  16'd822,  16'd840,  16'd857,  16'd875,  16'd892,  16'd910,  16'd928,
        16'd946,  16'd964,  16'd983,  16'd1001, 16'd1020, 16'd1038, 16'd1057, 16'd1076,
        16'd1095, 16'd1114, 16'd1133, 16'd1153, 16'd1172, 16'd1192, 16'd1211, 16'd1231,
        16'd1251, 16'd1271, 16'd1291, 16'd1311, 16'd1332, 16'd1352, 16'd1373, 16'd1393,
        16'd1414, 16'd1435, 16'd1456, 16'd1477, 16'd1498, 16'd1520, 16'd1541, 16'd1562,
        16'd1584, 16'd1606, 16'd1628, 16'd1649, 16'd1671, 16'd1694, 16'd1716, 16'd1738,
        16'd1760, 16'd1783, 16'd1806, 16'd1828, 16'd1851, 16'd1874, 16'd1897, 16'd1920,
        16'd1935, 16'd1942, 16'd1949, 16'd1955, 16'd1961, 16'd1968, 16'd1974, 16'd1980,
        16'd1985, 16'd1991, 16'd1996, 16'd2001, 16'd2006, 16'd2011, 16'd2016, 16'd2021,
        16'd2025, 16'd2029, 16'd2033, 16'd2037, 16'd2040, 16'd2044, 16'd2047, 16'd2050,
        16'd2053, 16'd2056, 16'd2058, 16'd2061, 16'd2063, 16'd2065, 16'd2066, 16'd2068,
        16'd2069, 16'd2070, 16'd2071, 16'd2072, 16'd2072, 16'd2072, 16'd2072, 16'd2072,
        16'd2072, 16'd2071, 16'd2070, 16'd2069, 16'd2068, 16'd2066, 16'd2065, 16'd2063,
        16'd2060, 16'd2058, 16'd2055, 16'd2052, 16'd2049, 16'd2045, 16'd2042, 16'd2038,
        16'd2033, 16'd2029, 16'd2024, 16'd2019, 16'd2013, 16'd2008, 16'd2002, 16'd1996,
        16'd1989, 16'd1982, 16'd1975, 16'd1968, 16'd1960, 16'd1952, 16'd1943, 16'd1934,
        16'd1925, 16'd1916, 16'd1906, 16'd1896, 16'd1885, 16'd1874, 16'd1863, 16'd1851,
        16'd1839, 16'd1827, 16'd1814, 16'd1800, 16'd1786, 16'd1772, 16'd1757, 16'd1742,
        16'd1727, 16'd1710, 16'd1694, 16'd1676, 16'd1659, 16'd1640, 16'd1622, 16'd1602,
        16'd1582, 16'd1561, 16'd1540, 16'd1518, 16'd1495, 16'd1471, 16'd1447, 16'd1422,
        16'd1396, 16'd1369, 16'd1341, 16'd1312, 16'd1282, 16'd1251, 16'd1219, 16'd1186,
        16'd1151, 16'd1114, 16'd1077, 16'd1037, 16'd995,  16'd952,  16'd906,  16'd857,
        16'd805,  16'd750,  16'd690,  16'd625,  16'd553,  16'd471,  16'd376,  16'd255
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_APPLY,
        ST_RENORM,
        ST_REL_HELD,
        ST_REL_RUN,
        ST_SETTLE,
        ST_FL_SEARCH,
        ST_FL_SHIFT,
        ST_FL_B2,
        ST_FL_B1,
        ST_FL_B0,
        ST_FINISH,
        ST_CLEAR
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MULT,
        OP_APPLY,
        OP_DOUBLE,
        OP_EMIT_HELD,
        OP_EMIT_RUN,
        OP_SETTLE,
        OP_FL_SEARCH,
        OP_FL_SHIFT,
        OP_FL_CARRY,
        OP_FL_B2,
        OP_FL_B1,
        OP_FL_B0,
        OP_FINISH,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic renorm_need;
        logic rel_req;
        logic held_valid;
        logic run_nz;
        logic emit_ok;
        logic search_hit;
        logic shift_lt8;
        logic extra;
    } status_t;

endpackage

// ===== sv/abae_in_if.sv =====
// ----------------------------------------------------------------------------
// abae_in_if
// Input channel of the encoder: one encode or flush request per word.
// ----------------------------------------------------------------------------
interface abae_in_if;

    logic       valid;
    logic       ready;
    logic       operation;
    logic [6:0] context_req;
    logic       bit_req;

    modport source (output valid, output operation, output context_req, output bit_req,
                    input ready);
    modport sink   (input valid, input operation, input context_req, input bit_req,
                    output ready);

endinterface

// ===== sv/abae_out_if.sv =====
// ----------------------------------------------------------------------------
// abae_out_if
// Output channel of the encoder: one coded byte per word.
// ----------------------------------------------------------------------------
interface abae_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       run_overflow;

    modport source (output valid, output out_byte, output last, output run_overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input run_overflow,
                    output ready);

endinterface

// ===== sv/abae_ram.sv =====
// ----------------------------------------------------------------------------
// abae_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/abae_ctrl.sv =====
// ----------------------------------------------------------------------------
// abae_ctrl
// Sequencer of the encoder: steps the datapath through split, renormalisation,
// byte release and stream termination.
// ----------------------------------------------------------------------------
module abae_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_operation,
    output logic              in_ready,
    input  abae_pkg::status_t status,
    output abae_pkg::op_t     op
);

    abae_pkg::state_t state_reg;
    abae_pkg::state_t state_next;
    logic             flush_reg;
    logic             flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= abae_pkg::ST_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        op         = abae_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            abae_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = abae_pkg::OP_LOAD;
                    flush_next = (in_operation == abae_pkg::OPER_FLUSH);
                    state_next = (in_operation == abae_pkg::OPER_FLUSH) ?
                                 abae_pkg::ST_FL_SEARCH : abae_pkg::ST_MULT;
                end
            end
            abae_pkg::ST_MULT:
            begin
                op         = abae_pkg::OP_MULT;
                state_next = abae_pkg::ST_APPLY;
            end
            abae_pkg::ST_APPLY:
            begin
                op         = abae_pkg::OP_APPLY;
                state_next = abae_pkg::ST_RENORM;
            end
            abae_pkg::ST_RENORM:
            begin
                if (status.rel_req)
                begin
                    state_next = abae_pkg::ST_REL_HELD;
                end
                else if (status.renorm_need)
                begin
                    op = abae_pkg::OP_DOUBLE;
                end
                else
                begin
                    state_next = abae_pkg::ST_FINISH;
                end
            end
            abae_pkg::ST_REL_HELD:
            begin
                if (!status.held_valid)
                begin
                    state_next = abae_pkg::ST_REL_RUN;
                end
                else if (status.emit_ok)
                begin
                    op         = abae_pkg::OP_EMIT_HELD;
                    state_next = abae_pkg::ST_REL_RUN;
                end
            end
            abae_pkg::ST_REL_RUN:
            begin
                if (status.run_nz)
                begin
                    if (status.emit_ok)
                    begin
                        op = abae_pkg::OP_EMIT_RUN;
                    end
                end
                else
                begin
                    state_next = flush_reg ? abae_pkg::ST_FL_B2 : abae_pkg::ST_SETTLE;
                end
            end
            abae_pkg::ST_SETTLE:
            begin
                op         = abae_pkg::OP_SETTLE;
                state_next = abae_pkg::ST_RENORM;
            end
            abae_pkg::ST_FL_SEARCH:
            begin
                op = abae_pkg::OP_FL_SEARCH;
                if (status.search_hit)
                begin
                    state_next = abae_pkg::ST_FL_SHIFT;
                end
            end
            abae_pkg::ST_FL_SHIFT:
            begin
                if (status.shift_lt8)
                begin
                    op = abae_pkg::OP_FL_SHIFT;
                end
                else
                begin
                    op         = abae_pkg::OP_FL_CARRY;
                    state_next = abae_pkg::ST_REL_HELD;
                end
            end
            abae_pkg::ST_FL_B2:
            begin
                if (status.emit_ok)
                begin
                    op         = abae_pkg::OP_FL_B2;
                    state_next = abae_pkg::ST_FL_B1;
                end
            end
            abae_pkg::ST_FL_B1:
            begin
                if (status.emit_ok)
                begin
                    op         = abae_pkg::OP_FL_B1;
                    state_next = abae_pkg::ST_FL_B0;
                end
            end
            abae_pkg::ST_FL_B0:
            begin
                if (!status.extra)
                begin
                    state_next = abae_pkg::ST_FINISH;
                end
                else if (status.emit_ok)
                begin
                    op         = abae_pkg::OP_FL_B0;
                    state_next = abae_pkg::ST_FINISH;
                end
            end
            abae_pkg::ST_FINISH:
            begin
                if (status.emit_ok)
                begin
                    op         = abae_pkg::OP_FINISH;
                    state_next = flush_reg ? abae_pkg::ST_CLEAR : abae_pkg::ST_IDLE;
                end
            end
            abae_pkg::ST_CLEAR:
            begin
                op         = abae_pkg::OP_CLEAR;
                flush_next = 1'b0;
                state_next = abae_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = abae_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/abae_dp.sv =====
// ----------------------------------------------------------------------------
// abae_dp
// Datapath of the encoder: interval registers, context store, carry run and
// the output stage that marks the final byte of each request.
// ----------------------------------------------------------------------------
`include "adaptive_binary_arith_encoder_assert.svh"

module abae_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  abae_pkg::op_t              op,
    output abae_pkg::status_t          status,
    input  logic [6:0]                 context_req,
    input  logic                       bit_req,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [7:0]                 out_byte,
    output logic                       last,
    output logic                       run_overflow
);

    logic [24:0] low_reg, low_next;
    logic [15:0] range_reg, range_next;
    logic [3:0]  shift_reg, shift_next;
    logic [4:0]  outst_reg, outst_next;
    logic [7:0]  held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic        ovf_reg, ovf_next;
    logic        carry_reg, carry_next;
    logic        rel_req_reg, rel_req_next;
    logic        extra_reg, extra_next;
    logic [15:0] mask_reg, mask_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [abae_pkg::CTX_W-1:0] ctx_reg, ctx_next;
    logic        bit_reg, bit_next;
    logic [15:0] p_reg, p_next;
    logic [15:0] sub_reg, sub_next;
    logic [abae_pkg::NUM_CONTEXTS-1:0] valid_reg, valid_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        out_ovf_reg, out_ovf_next;

    logic [abae_pkg::CTX_W-1:0] ctx_in;
    logic [15:0] ram_rdata;
    logic [15:0] p_sel;
    logic [31:0] prod;
    logic [24:0] lo2;
    logic [15:0] rg2;
    logic [3:0]  sh2;
    logic [25:0] lo_sum;
    logic        straddle;
    logic [16:0] cand;
    logic [24:0] or_val;
    logic        hit;
    logic        emit_ok;
    logic        emit_valid;
    logic [7:0]  emit_byte;
    logic        ram_we;

    // Indexes past the last context fall onto the last context.
    assign ctx_in = (int'(context_req) >= abae_pkg::NUM_CONTEXTS) ?
                    abae_pkg::CTX_W'(abae_pkg::NUM_CONTEXTS - 1) :
                    abae_pkg::CTX_W'(context_req);

    assign ram_we = (op == abae_pkg::OP_APPLY);

    abae_ram #(
        .WIDTH (16),
        .DEPTH (abae_pkg::NUM_CONTEXTS)
    ) u_prob_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ctx_reg),
        .wdata (p_next),
        .raddr (ctx_in),
        .rdata (ram_rdata)
    );

    // A context not written since reset or the last flush reads as one half.
    assign p_sel = valid_reg[ctx_reg] ? ram_rdata : abae_pkg::PROB_INIT;
    assign prod  = range_reg * p_sel;

    assign lo2      = {low_reg[23:0], 1'b0};
    assign rg2      = {range_reg[14:0], 1'b0};
    assign sh2      = shift_reg + 4'd1;
    assign lo_sum   = {1'b0, lo2} + {10'd0, rg2};
    assign straddle = !lo2[24] && (lo_sum[25:24] != 2'd0);

    assign cand   = {mask_reg, 1'b1};
    assign or_val = low_reg | {8'd0, cand};
    assign hit    = (cnt_reg == 5'd16) ||
                    ((range_reg != 16'd0) && (or_val > {9'd0, range_reg - 16'd1}));

    assign emit_ok = !pend_valid_reg || !out_valid_reg || out_ready;

    always_comb
    begin
        emit_valid = 1'b1;
        emit_byte  = 8'd0;
        case (op)
            abae_pkg::OP_EMIT_HELD: emit_byte = held_reg + {7'd0, carry_reg};
            abae_pkg::OP_EMIT_RUN:  emit_byte = carry_reg ? 8'h00 : 8'hff;
            abae_pkg::OP_FL_B2:     emit_byte = low_reg[23:16];
            abae_pkg::OP_FL_B1:     emit_byte = low_reg[15:8];
            abae_pkg::OP_FL_B0:     emit_byte = low_reg[7:0];
            default:                emit_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        low_next        = low_reg;
        range_next      = range_reg;
        shift_next      = shift_reg;
        outst_next      = outst_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        ovf_next        = ovf_reg;
        carry_next      = carry_reg;
        rel_req_next    = rel_req_reg;
        extra_next      = extra_reg;
        mask_next       = mask_reg;
        cnt_next        = cnt_reg;
        ctx_next        = ctx_reg;
        bit_next        = bit_reg;
        p_next          = p_reg;
        sub_next        = sub_reg;
        valid_next      = valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (op)
            abae_pkg::OP_LOAD:
            begin
                ctx_next   = ctx_in;
                bit_next   = bit_req;
                extra_next = (shift_reg != 4'd0);
                mask_next  = 16'd0;
                cnt_next   = 5'd0;
            end
            abae_pkg::OP_MULT:
            begin
                p_next   = p_sel;
                sub_next = prod[31:16];
            end
            abae_pkg::OP_APPLY:
            begin
                valid_next[ctx_reg] = 1'b1;
                if (bit_reg)
                begin
                    low_next   = low_reg + {9'd0, sub_reg};
                    range_next = range_reg - sub_reg;
                    p_next     = p_reg - abae_pkg::ADAPT_ROM[p_reg[15:8]];
                end
                else
                begin
                    range_next = sub_reg;
                    p_next     = p_reg + abae_pkg::ADAPT_ROM[~p_reg[15:8]];
                end
            end
            abae_pkg::OP_DOUBLE:
            begin
                low_next   = lo2;
                range_next = rg2;
                shift_next = sh2;
                if (sh2 == 4'd8)
                begin
                    if (straddle)
                    begin
                        if (int'(outst_reg) < abae_pkg::MAX_OUTSTANDING)
                        begin
                            outst_next = outst_reg + 5'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        low_next   = {9'd0, lo2[15:0]};
                        shift_next = 4'd0;
                    end
                    else
                    begin
                        // The byte settles; release and the new held byte follow.
                        rel_req_next = 1'b1;
                        carry_next   = lo2[24];
                    end
                end
            end
            abae_pkg::OP_EMIT_RUN:
            begin
                outst_next = outst_reg - 5'd1;
            end
            abae_pkg::OP_SETTLE:
            begin
                held_next       = low_reg[23:16];
                held_valid_next = 1'b1;
                low_next        = {9'd0, low_reg[15:0]};
                shift_next      = 4'd0;
                rel_req_next    = 1'b0;
            end
            abae_pkg::OP_FL_SEARCH:
            begin
                if (hit)
                begin
                    low_next = low_reg | {9'd0, mask_reg};
                end
                else
                begin
                    mask_next = cand[15:0];
                    cnt_next  = cnt_reg + 5'd1;
                end
            end
            abae_pkg::OP_FL_SHIFT:
            begin
                low_next   = {low_reg[23:0], 1'b1};
                shift_next = sh2;
            end
            abae_pkg::OP_FL_CARRY:
            begin
                carry_next = low_reg[24];
            end
            abae_pkg::OP_CLEAR:
            begin
                low_next        = 25'd0;
                range_next      = abae_pkg::RANGE_INIT;
                shift_next      = 4'd0;
                outst_next      = 5'd0;
                held_next       = 8'd0;
                held_valid_next = 1'b0;
                ovf_next        = 1'b0;
                rel_req_next    = 1'b0;
                valid_next      = '0;
            end
            default:
            begin
            end
        endcase

        // The newest byte waits in the pending stage until it is known
        // whether another byte of the same request follows it.
        if (emit_valid)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
                out_ovf_next   = ovf_reg;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
        else if ((op == abae_pkg::OP_FINISH) && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_last_next   = 1'b1;
            out_ovf_next    = ovf_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= 25'd0;
            range_reg      <= abae_pkg::RANGE_INIT;
            shift_reg      <= 4'd0;
            outst_reg      <= 5'd0;
            held_reg       <= 8'd0;
            held_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            carry_reg      <= 1'b0;
            rel_req_reg    <= 1'b0;
            extra_reg      <= 1'b0;
            mask_reg       <= 16'd0;
            cnt_reg        <= 5'd0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            low_reg        <= low_next;
            range_reg      <= range_next;
            shift_reg      <= shift_next;
            outst_reg      <= outst_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            ovf_reg        <= ovf_next;
            carry_reg      <= carry_next;
            rel_req_reg    <= rel_req_next;
            extra_reg      <= extra_next;
            mask_reg       <= mask_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg       <= ctx_next;
        bit_reg       <= bit_next;
        p_reg         <= p_next;
        sub_reg       <= sub_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign status.renorm_need = (range_reg != 16'd0) && (range_reg <= abae_pkg::RENORM_MAX);
    assign status.rel_req     = rel_req_reg;
    assign status.held_valid  = held_valid_reg;
    assign status.run_nz      = (outst_reg != 5'd0);
    assign status.emit_ok     = emit_ok;
    assign status.search_hit  = hit;
    assign status.shift_lt8   = (shift_reg < 4'd8);
    assign status.extra       = extra_reg;

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = out_last_reg;
    assign run_overflow = out_ovf_reg;

    `ABAE_ASSERT_NOW(a_run_bound, 1'b1, int'(outst_reg) <= abae_pkg::MAX_OUTSTANDING)
    `ABAE_ASSERT_NOW(a_release_at_byte, rel_req_reg, shift_reg == 4'd8)
    `ABAE_ASSERT_NEXT(a_clear_restores, op == abae_pkg::OP_CLEAR,
                      (range_reg == abae_pkg::RANGE_INIT) && (valid_reg == '0) && !ovf_reg)
    `ABAE_ASSERT_NOW(a_no_lost_word, emit_valid && pend_valid_reg,
                     !out_valid_reg || out_ready)

endmodule

// ===== sv/adaptive_binary_arith_encoder.sv =====
// ----------------------------------------------------------------------------
// adaptive_binary_arith_encoder
// Context-adaptive binary arithmetic encoder with carry resolution by a held
// byte and a run of outstanding 0xff bytes.
//
//   channel | dir | word
//   in_ch   | in  | operation, context_req[6:0], bit_req
//   out_ch  | out | out_byte[7:0], last, run_overflow
//
// An encode passes through the split and the apply step and then renormalises one
// doubling at a time (at most 15 doublings); each time a byte settles, the held byte
// and the outstanding run are released before the new held byte is taken.
// A flush runs up to 17 termination search steps, up to 8 shifts and the release of
// the held byte, outstanding run and final bytes; its last state restores the reset state.
// The context probabilities sit in a 128-entry RAM; per-entry valid flags make
// reset and flush clear them at once, so there is no clearing pass.
// Back-pressure on out_ch stalls the sequencer only when both the pending and
// the output word are occupied.
// ----------------------------------------------------------------------------
module adaptive_binary_arith_encoder (
    input  logic        clk,
    input  logic        rst_n,
    abae_in_if.sink     in_ch,
    abae_out_if.source  out_ch
);

    abae_pkg::op_t     op;
    abae_pkg::status_t status;

    abae_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_operation (in_ch.operation),
        .in_ready     (in_ch.ready),
        .status       (status),
        .op           (op)
    );

    abae_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .context_req  (in_ch.context_req),
        .bit_req      (in_ch.bit_req),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_byte     (out_ch.out_byte),
        .last         (out_ch.last),
        .run_overflow (out_ch.run_overflow)
    );

endmodule

// ===== verif/tb_adaptive_binary_arith_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_adaptive_binary_arith_encoder
// Self-checking bench for the adaptive binary arithmetic encoder. A bit-exact
// predictor of the coder tracks every accepted request and queues the bytes
// it must produce. A monitor compares each coded byte with the oldest entry.
// The sender works in bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module tb_adaptive_binary_arith_encoder;

    typedef struct packed {
        logic       operation;
        logic [6:0] context_req;
        logic       bit_req;
    } request_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       run_overflow;
    } coded_t;

    localparam int BYTE_BUDGET = 34;
    localparam int IDLE_LIMIT  = 4000;

    logic clk;
    logic rst_n;

    abae_in_if  in_ch ();
    abae_out_if out_ch ();

    adaptive_binary_arith_encoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    request_t    pending_requests[$];
    coded_t      expected_bytes[$];
    int          error_count;
    int          idle_cycles;

    // Predictor state.
    int unsigned low_value;
    int unsigned interval_width;
    int unsigned shift_count;
    int unsigned outstanding;
    int unsigned held_byte;
    bit          held_valid;
    bit          overflow_flag;
    logic [15:0] ctx_prob [abae_pkg::NUM_CONTEXTS];

    logic [7:0]  coded_buf [BYTE_BUDGET];
    int          coded_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    task automatic coder_reset();
        low_value      = 0;
        interval_width = abae_pkg::RANGE_INIT;
        shift_count    = 0;
        outstanding    = 0;
        held_byte      = 0;
        held_valid     = 1'b0;
        overflow_flag  = 1'b0;
        for (int k = 0; k < abae_pkg::NUM_CONTEXTS; k++)
            ctx_prob[k] = abae_pkg::PROB_INIT;
    endtask

    task automatic push_byte(input int unsigned b);
        if (coded_count >= BYTE_BUDGET)
            overflow_flag = 1'b1;
        else
        begin
            coded_buf[coded_count] = b[7:0];
            coded_count++;
        end
    endtask

    task automatic release_run(input bit carry);
        if (held_valid)
            push_byte(held_byte + carry);
        while (outstanding > 0)
        begin
            push_byte(carry ? 8'h00 : 8'hff);
            outstanding--;
        end
    endtask

    task automatic encode_request(input request_t req);
        int unsigned ctx;
        int unsigned p;
        int unsigned sub;
        bit          extra;
        int unsigned i;
        coded_t      word;
        coded_count = 0;
        if (req.operation == abae_pkg::OPER_ENCODE)
        begin
            ctx = req.context_req;
            if (ctx >= abae_pkg::NUM_CONTEXTS)
                ctx = abae_pkg::NUM_CONTEXTS - 1;
            p   = ctx_prob[ctx];
            sub = (interval_width * p) >> 16;
            if (req.bit_req)
            begin
                low_value      = (low_value + sub) & 32'h1ffffff;
                interval_width = (interval_width - sub) & 32'hffff;
                p = (p - abae_pkg::ADAPT_ROM[(p >> 8) & 8'hff]) & 32'hffff;
            end
            else
            begin
                interval_width = sub & 32'hffff;
                p = (p + abae_pkg::ADAPT_ROM[255 - ((p >> 8) & 8'hff)]) & 32'hffff;
            end
            ctx_prob[ctx] = p[15:0];
            while (interval_width != 0 && interval_width <= abae_pkg::RENORM_MAX)
            begin
                low_value      = (low_value << 1) & 32'h1ffffff;
                interval_width = (interval_width << 1) & 32'hffff;
                shift_count++;
                if (shift_count >= 8)
                begin
                    // A byte that might still take a carry joins the outstanding run.
                    if (low_value < (1 << 24) && low_value + interval_width >= (1 << 24))
                    begin
                        if (outstanding < abae_pkg::MAX_OUTSTANDING)
                            outstanding++;
                        else
                            overflow_flag = 1'b1;
                    end
                    else
                    begin
                        release_run(low_value >= (1 << 24));
                        held_byte  = (low_value >> 16) & 8'hff;
                        held_valid = 1'b1;
                    end
                    low_value   &= 32'hffff;
                    shift_count  = 0;
                end
            end
        end
        else
        begin
            extra = shift_count > 0;
            for (i = 0; i < 16; i++)
                if ((low_value | ((32'd1 << (i + 1)) - 1)) > interval_width - 32'd1)
                    break;
            low_value |= (32'd1 << i) - 1;
            while (shift_count < 8)
            begin
                low_value = ((low_value << 1) | 1) & 32'h1ffffff;
                shift_count++;
            end
            release_run(low_value >= (1 << 24));
            push_byte(low_value >> 16);
            push_byte(low_value >> 8);
            if (extra)
                push_byte(low_value);
        end
        for (int k = 0; k < coded_count; k++)
        begin
            word.out_byte     = coded_buf[k];
            word.last         = (k == coded_count - 1);
            word.run_overflow = overflow_flag;
            expected_bytes.push_back(word);
        end
        if (req.operation == abae_pkg::OPER_FLUSH)
            coder_reset();
    endtask

    function automatic request_t make_request(input logic op, input int ctx, input logic b);
        request_t r;
        r.operation   = op;
        r.context_req = ctx[6:0];
        r.bit_req     = b;
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.operation   <= abae_pkg::OPER_ENCODE;
            in_ch.context_req <= '0;
            in_ch.bit_req     <= 1'b0;
            burst_left        <= 0;
            gap_left          <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.operation   <= r.operation;
                in_ch.context_req <= r.context_req;
                in_ch.bit_req     <= r.bit_req;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: the stall pattern is redrawn at random from four modes, one of them always ready.
    int stall_mode;
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_mode   <= 0;
            stall_phase  <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= (stall_phase % 4 == 0);
                default: out_ch.ready <= (stall_phase % 16) < 11;
            endcase
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                encode_request(make_request(in_ch.operation, in_ch.context_req,
                                            in_ch.bit_req));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected word: out_byte %h", out_ch.out_byte);
                    error_count++;
                end
                else
                begin
                    coded_t exp_w;
                    exp_w = expected_bytes.pop_front();
                    if (out_ch.out_byte !== exp_w.out_byte)
                    begin
                        $error("out_byte expected %h actual %h", exp_w.out_byte,
                               out_ch.out_byte);
                        error_count++;
                    end
                    if (out_ch.last !== exp_w.last)
                    begin
                        $error("last expected %b actual %b", exp_w.last, out_ch.last);
                        error_count++;
                    end
                    if (out_ch.run_overflow !== exp_w.run_overflow)
                    begin
                        $error("run_overflow expected %b actual %b", exp_w.run_overflow,
                               out_ch.run_overflow);
                        error_count++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("tb_adaptive_binary_arith_encoder: errors");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int hot_ctx;
        int skew;
        int run_len;
        error_count = 0;
        idle_cycles = 0;
        coder_reset();
        rst_n = 1'b0;

        // Directed: empty flush, extreme contexts, long skewed runs, flush of each kind.
        pending_requests.push_back(make_request(abae_pkg::OPER_FLUSH, 127, 1'b1));
        pending_requests.push_back(make_request(abae_pkg::OPER_ENCODE, 0, 1'b0));
        pending_requests.push_back(make_request(abae_pkg::OPER_ENCODE, 127, 1'b1));
        pending_requests.push_back(make_request(abae_pkg::OPER_FLUSH, 0, 1'b0));
        for (int k = 0; k < 8; k++)
            pending_requests.push_back(make_request(abae_pkg::OPER_ENCODE, 127, 1'b1));
        for (int k = 0; k < 8; k++)
            pending_requests.push_back(make_request(abae_pkg::OPER_ENCODE, 85, 1'b0));
        pending_requests.push_back(make_request(abae_pkg::OPER_FLUSH, 42, 1'b1));
        pending_requests.push_back(make_request(abae_pkg::OPER_FLUSH, 0, 1'b0));

        // Random streams: a few busy contexts with skewed bits drive the
        // probabilities towards their limits, with the odd stray context.
        while (pending_requests.size() < 260)
        begin
            hot_ctx = $urandom_range(0, 127);
            skew    = $urandom_range(0, 100);
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len; k++)
            begin
                int ctx;
                ctx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                  : hot_ctx + $urandom_range(0, 2);
                if (ctx > 127)
                    ctx = 127;
                pending_requests.push_back(make_request(abae_pkg::OPER_ENCODE, ctx,
                    $urandom_range(0, 99) < skew));
            end
            pending_requests.push_back(make_request(abae_pkg::OPER_FLUSH,
                                                    $urandom_range(0, 127),
                                                    1'($urandom_range(0, 1))));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (in_ch.valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("tb_adaptive_binary_arith_encoder: clean");
        else
            $display("tb_adaptive_binary_arith_encoder: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/abae_pkg.sv
sv/abae_in_if.sv
sv/abae_out_if.sv
sv/abae_ram.sv
sv/abae_ctrl.sv
sv/abae_dp.sv
sv/adaptive_binary_arith_encoder.sv
verif/tb_adaptive_binary_arith_encoder.sv
